>>> rtl/core/lths_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lths_pkg;

    // Link phases; codes 5..7 are never entered
    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_HELLO = 3'd1,
        PH_WAIT  = 3'd2,
        PH_SEND  = 3'd3,
        PH_RECV  = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        OP_RECEIVE    = 3'd0,
        OP_NEXT_TX    = 3'd1,
        OP_HELLO_QRY  = 3'd2,
        OP_LINK_UP    = 3'd3,
        OP_ERR_REPORT = 3'd4,
        OP_READ_CLEAR = 3'd5
    } op_t;

    // Decoded outcome of a received message
    typedef enum logic [3:0] {
        RX_NONE,
        RX_HELLO_WIN,
        RX_HELLO_LOSE,
        RX_HELLO_SAME,
        RX_START,
        RX_WAIT_HELLO,
        RX_ADVANCE,
        RX_DROP,
        RX_DROP_ERR,
        RX_FAIL,
        RX_BAD
    } rx_act_t;

    localparam logic [2:0] STATUS_ERR = 3'd5;
    localparam logic [31:0] SEQ_STEP  = 32'd2;

    localparam logic [31:0] FLAG_SAME  = 32'h0000_0001;
    localparam logic [31:0] FLAG_SEQ   = 32'h0000_0002;
    localparam logic [31:0] FLAG_STATE = 32'h0000_0004;

    localparam logic signed [1:0] VERDICT_ADV  = 2'sd1;
    localparam logic signed [1:0] VERDICT_NONE = 2'sd0;
    localparam logic signed [1:0] VERDICT_FAIL = -2'sd1;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_OWN_UPPER   = 3'd0;
    localparam logic [2:0] REG_OWN_LOWER   = 3'd1;
    localparam logic [2:0] REG_HELLO_LIMIT = 3'd2;
    localparam logic [2:0] REG_TYPE_MASK   = 3'd3;
    localparam logic [2:0] REG_NOP_CODE    = 3'd4;
    localparam logic [2:0] REG_HELLO_CODE  = 3'd5;
    localparam logic [2:0] REG_EVENT_CODE  = 3'd6;
    localparam logic [2:0] REG_HELLO_LOWER = 3'd7;

    typedef struct packed {
        logic [15:0] own_upper;
        logic [31:0] own_lower;
        logic [15:0] hello_limit;
        logic [15:0] type_mask;
        logic [15:0] nop_code;
        logic [15:0] hello_code;
        logic [15:0] event_code;
        logic [31:0] hello_lower;
    } lths_cfg_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] source_upper;
        logic [31:0] source_lower;
        logic [15:0] dest_upper;
        logic [31:0] dest_lower;
        logic [31:0] reported_flags;
    } lths_item_t;

    typedef struct packed {
        phase_t      phase;
        logic [31:0] seq_sent;
        logic [31:0] seq_known;
        logic [31:0] seq_next;
        logic [31:0] hello_cnt;
        logic [47:0] peer;
        logic        peer_seen;
        logic [31:0] tally;
        logic [31:0] first_flags;
        logic [31:0] or_flags;
        logic [2:0]  snap_phase;
        logic [31:0] snap_known;
        logic [31:0] snap_sent;
    } lths_state_t;

    typedef struct packed {
        logic signed [1:0] verdict;
        logic              tx_valid;
        logic [15:0]       tx_upper;
        logic [31:0]       tx_lower;
        logic [2:0]        link_status;
        logic [31:0]       errors_seen;
        logic [31:0]       first_error;
        logic [31:0]       later_errors;
        logic [2:0]        snap_status;
        logic [31:0]       snap_known;
        logic [31:0]       snap_sent;
        logic [47:0]       peer_address;
    } lths_result_t;

endpackage

`default_nettype wire

>>> rtl/core/lths_step.sv
`timescale 1ns / 1ps
`default_nettype none

// One beat of the handshake machine: next state and result from the
// current state and one item.
module lths_step (
    input  var lths_pkg::lths_cfg_t    cfg,
    input  var lths_pkg::lths_state_t  state,
    input  var lths_pkg::lths_item_t   item,
    output lths_pkg::lths_state_t      state_next,
    output lths_pkg::lths_result_t     result
);
    import lths_pkg::*;

    logic [15:0] kind;
    logic [47:0] own_addr;
    logic [47:0] src_addr;
    rx_act_t     rx_act;
    logic [31:0] hello_inc;
    logic        err_req;
    logic [31:0] err_flags;

    assign kind      = item.dest_upper & cfg.type_mask;
    assign own_addr  = {cfg.own_upper, cfg.own_lower};
    assign src_addr  = {item.source_upper, item.source_lower};
    assign hello_inc = (state.hello_cnt == '1) ? state.hello_cnt : state.hello_cnt + 32'd1;

    // receive decode
    always_comb begin
        rx_act = RX_NONE;
        if (kind != cfg.nop_code) begin
            unique case (state.phase)
                PH_IDLE: begin
                    rx_act = RX_NONE;
                end
                PH_HELLO: begin
                    priority if (kind == cfg.hello_code) begin
                        priority if (own_addr > src_addr) rx_act = RX_HELLO_WIN;
                        else if (own_addr == src_addr)    rx_act = RX_HELLO_SAME;
                        else                              rx_act = RX_HELLO_LOSE;
                    end else if (kind == cfg.event_code && item.dest_lower == 32'd0) begin
                        rx_act = RX_START;
                    end else begin
                        rx_act = RX_NONE;
                    end
                end
                PH_WAIT: begin
                    priority if (kind == cfg.hello_code) begin
                        rx_act = RX_WAIT_HELLO;
                    end else if (kind == cfg.event_code) begin
                        rx_act = (item.dest_lower == state.seq_sent + 32'd1) ?
                                 RX_ADVANCE : RX_DROP;
                    end else begin
                        rx_act = RX_DROP_ERR;
                    end
                end
                PH_SEND: begin
                    rx_act = (kind == cfg.event_code && item.dest_lower == state.seq_known) ?
                             RX_NONE : RX_FAIL;
                end
                PH_RECV: begin
                    priority if (kind == cfg.event_code &&
                                 state.seq_known + SEQ_STEP == item.dest_lower) begin
                        rx_act = RX_ADVANCE;
                    end else if (kind == cfg.event_code &&
                                 state.seq_known == item.dest_lower) begin
                        rx_act = RX_NONE;
                    end else begin
                        rx_act = RX_FAIL;
                    end
                end
                default: begin
                    rx_act = RX_BAD;
                end
            endcase
        end
    end

    // error recording request
    always_comb begin
        err_req   = 1'b0;
        err_flags = '0;
        if (item.op == OP_ERR_REPORT) begin
            err_req   = 1'b1;
            err_flags = item.reported_flags;
        end else if (item.op == OP_RECEIVE) begin
            unique case (rx_act)
                RX_HELLO_SAME: begin
                    err_req   = 1'b1;
                    err_flags = FLAG_SAME;
                end
                RX_DROP_ERR, RX_FAIL: begin
                    err_req   = 1'b1;
                    err_flags = FLAG_SEQ;
                end
                RX_BAD: begin
                    err_req   = 1'b1;
                    err_flags = FLAG_STATE;
                end
                default: begin
                    err_req   = 1'b0;
                end
            endcase
        end
    end

    // next state
    always_comb begin
        state_next = state;

        if (err_req) begin
            if (state.tally == 32'd0) begin
                state_next.snap_known  = state.seq_known;
                state_next.snap_sent   = state.seq_sent;
                state_next.snap_phase  = state.phase;
                state_next.first_flags = err_flags;
            end else begin
                state_next.or_flags = state.or_flags | err_flags;
            end
            if (state.tally != '1) begin
                state_next.tally = state.tally + 32'd1;
            end
        end

        unique case (item.op)
            OP_RECEIVE: begin
                unique case (rx_act)
                    RX_HELLO_WIN: begin
                        state_next.peer      = src_addr;
                        state_next.peer_seen = 1'b1;
                        state_next.seq_sent  = '0;
                        state_next.seq_known = '0;
                        state_next.seq_next  = '0;
                        state_next.phase     = PH_WAIT;
                    end
                    RX_HELLO_LOSE: begin
                        state_next.peer      = src_addr;
                        state_next.peer_seen = 1'b1;
                    end
                    RX_HELLO_SAME: begin
                        state_next.peer      = src_addr;
                        state_next.peer_seen = 1'b1;
                        state_next.phase     = PH_IDLE;
                    end
                    RX_START: begin
                        state_next.seq_known = '0;
                        state_next.seq_next  = 32'd1;
                        state_next.phase     = PH_SEND;
                    end
                    RX_WAIT_HELLO: begin
                        state_next.hello_cnt = hello_inc;
                        if (hello_inc > {16'd0, cfg.hello_limit}) begin
                            state_next.seq_sent  = '0;
                            state_next.seq_known = '0;
                            state_next.seq_next  = '0;
                            state_next.phase     = PH_HELLO;
                        end
                    end
                    RX_ADVANCE: begin
                        state_next.seq_known = item.dest_lower;
                        state_next.seq_next  = item.dest_lower + 32'd1;
                        state_next.phase     = PH_SEND;
                    end
                    RX_DROP, RX_DROP_ERR, RX_FAIL: begin
                        state_next.seq_sent  = '0;
                        state_next.seq_known = '0;
                        state_next.seq_next  = '0;
                        state_next.phase     = PH_HELLO;
                    end
                    RX_BAD: begin
                        state_next.seq_sent  = '0;
                        state_next.seq_known = '0;
                        state_next.seq_next  = '0;
                        state_next.phase     = PH_IDLE;
                    end
                    default: begin
                        state_next.phase = state.phase;
                    end
                endcase
            end
            OP_NEXT_TX: begin
                if (state.phase == PH_SEND) begin
                    state_next.seq_sent = state.seq_next;
                    state_next.seq_next = state.seq_next + SEQ_STEP;
                    state_next.phase    = PH_RECV;
                end
            end
            OP_LINK_UP: begin
                if (state.phase == PH_IDLE) begin
                    state_next.phase = PH_HELLO;
                end
            end
            OP_READ_CLEAR: begin
                state_next.tally = '0;
            end
            default: begin
                state_next.phase = state.phase;
            end
        endcase
    end

    // result
    always_comb begin
        result = '0;

        if (item.op == OP_RECEIVE) begin
            unique case (rx_act)
                RX_HELLO_WIN, RX_START, RX_ADVANCE: result.verdict = VERDICT_ADV;
                RX_FAIL:                            result.verdict = VERDICT_FAIL;
                default:                            result.verdict = VERDICT_NONE;
            endcase
        end

        if (item.op == OP_NEXT_TX || item.op == OP_HELLO_QRY) begin
            unique case (state.phase)
                PH_HELLO: begin
                    result.tx_valid = 1'b1;
                    result.tx_upper = cfg.hello_code;
                    result.tx_lower = cfg.hello_lower;
                end
                PH_WAIT: begin
                    result.tx_valid = 1'b1;
                    result.tx_upper = cfg.event_code;
                end
                PH_SEND: begin
                    if (item.op == OP_NEXT_TX) begin
                        result.tx_valid = 1'b1;
                        result.tx_upper = cfg.event_code;
                        result.tx_lower = state.seq_next;
                    end
                end
                default: begin
                    if (item.op == OP_NEXT_TX) begin
                        result.tx_valid = 1'b1;
                        result.tx_upper = cfg.nop_code;
                    end
                end
            endcase
        end

        result.link_status  = (state_next.tally != 32'd0) ? STATUS_ERR : state_next.phase;
        result.errors_seen  = (item.op == OP_READ_CLEAR) ? state.tally : state_next.tally;
        result.first_error  = state_next.first_flags;
        result.later_errors = state_next.or_flags;
        result.snap_status  = state_next.snap_phase;
        result.snap_known   = state_next.snap_known;
        result.snap_sent    = state_next.snap_sent;
        result.peer_address = state_next.peer_seen ? state_next.peer : 48'd0;
    end

endmodule

`default_nettype wire

>>> rtl/core/link_token_handshake_fsm_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Link token handshake state machine.
// Input stream (s_*): one beat per link event. s_tuser carries the operation
// code (receive, next transmit, hello query, link up, error report, error
// read-clear); s_tdata carries the message words and reported error flags.
// Output stream (m_*): exactly one result beat per input beat, in order,
// holding the receive verdict, any message to transmit, link status, the
// error record and the peer address.
// APB port: eight 32-bit registers at byte addresses 0x00..0x1C, written in
// the access phase, pready tied high; the user must write only while idle,
// which the block itself does not enforce. Datapath: an accepted beat is held
// in an input register, evaluated combinationally against the link state and
// lands in the output register. Throughput: one beat per cycle while m_tready
// stays high, set by the combinational state update between those registers.
// Stall: while m_tready is low the result holds; the input register still
// takes one more beat, then s_tready drops until the result is taken.
// Reset (aresetn low, synchronous): phase idle, sequence numbers, counters,
// peer and error record cleared, registers back to their defaults.
module link_token_handshake_fsm_top (
    input  wire          aclk,
    input  wire          aresetn,
    // input stream
    input  wire          s_tvalid,
    output logic         s_tready,
    // s_tdata: source_upper[15:0], source_lower[47:16], dest_upper[63:48],
    //          dest_lower[95:64], reported_flags[127:96]
    input  wire  [127:0] s_tdata,
    // s_tuser: operation[2:0]
    input  wire  [2:0]   s_tuser,
    // result stream
    output logic         m_tvalid,
    input  wire          m_tready,
    // m_tdata: verdict[1:0], tx_valid[2], tx_upper[18:3], tx_lower[50:19],
    //          link_status[53:51], errors_seen[85:54], first_error[117:86],
    //          later_errors[149:118], snap_status[152:150], snap_known[184:153],
    //          snap_sent[216:185], peer_address[264:217], zero fill[271:265]
    output logic [271:0] m_tdata,
    // configuration
    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire  [4:0]   paddr,
    input  wire  [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import lths_pkg::*;

    lths_cfg_t    cfg_reg;
    lths_state_t  state_reg;
    lths_state_t  state_next;
    lths_item_t   item_reg;
    lths_result_t step_res;
    logic         in_valid_reg;
    logic         out_valid_reg;
    logic [271:0] out_data_reg;
    logic         advance;
    logic         cfg_wr;
    logic [2:0]   cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    // beat moves from input register to output register
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.own_upper   <= 16'd0;
            cfg_reg.own_lower   <= 32'd0;
            cfg_reg.hello_limit <= 16'd16;
            cfg_reg.type_mask   <= 16'hC000;
            cfg_reg.nop_code    <= 16'h0000;
            cfg_reg.hello_code  <= 16'h4000;
            cfg_reg.event_code  <= 16'h8000;
            cfg_reg.hello_lower <= 32'd0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_OWN_UPPER:   cfg_reg.own_upper   <= pwdata[15:0];
                REG_OWN_LOWER:   cfg_reg.own_lower   <= pwdata;
                REG_HELLO_LIMIT: cfg_reg.hello_limit <= pwdata[15:0];
                REG_TYPE_MASK:   cfg_reg.type_mask   <= pwdata[15:0];
                REG_NOP_CODE:    cfg_reg.nop_code    <= pwdata[15:0];
                REG_HELLO_CODE:  cfg_reg.hello_code  <= pwdata[15:0];
                REG_EVENT_CODE:  cfg_reg.event_code  <= pwdata[15:0];
                REG_HELLO_LOWER: cfg_reg.hello_lower <= pwdata;
                default:         cfg_reg.hello_lower <= cfg_reg.hello_lower;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_OWN_UPPER:   prdata = {16'd0, cfg_reg.own_upper};
            REG_OWN_LOWER:   prdata = cfg_reg.own_lower;
            REG_HELLO_LIMIT: prdata = {16'd0, cfg_reg.hello_limit};
            REG_TYPE_MASK:   prdata = {16'd0, cfg_reg.type_mask};
            REG_NOP_CODE:    prdata = {16'd0, cfg_reg.nop_code};
            REG_HELLO_CODE:  prdata = {16'd0, cfg_reg.hello_code};
            REG_EVENT_CODE:  prdata = {16'd0, cfg_reg.event_code};
            REG_HELLO_LOWER: prdata = cfg_reg.hello_lower;
            default:         prdata = 32'd0;
        endcase
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.op             <= op_t'(s_tuser);
            item_reg.source_upper   <= s_tdata[15:0];
            item_reg.source_lower   <= s_tdata[47:16];
            item_reg.dest_upper     <= s_tdata[63:48];
            item_reg.dest_lower     <= s_tdata[95:64];
            item_reg.reported_flags <= s_tdata[127:96];
        end
    end

    lths_step u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .item       (item_reg),
        .state_next (state_next),
        .result     (step_res)
    );

    // link state; own-address writes forget the peer unless a beat advances
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end else if (cfg_wr && (cfg_idx == REG_OWN_UPPER || cfg_idx == REG_OWN_LOWER)) begin
            state_reg.peer_seen <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {7'd0,
                             step_res.peer_address,
                             step_res.snap_sent,
                             step_res.snap_known,
                             step_res.snap_status,
                             step_res.later_errors,
                             step_res.first_error,
                             step_res.errors_seen,
                             step_res.link_status,
                             step_res.tx_lower,
                             step_res.tx_upper,
                             step_res.tx_valid,
                             step_res.verdict};
        end
    end

`ifndef SYNTHESIS
    // a held item is never dropped while the result side is blocked
    a_item_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("pending item lost");

    // no transmit words without tx_valid
    a_tx_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[2]) |-> (m_tdata[50:3] == 48'd0))
        else $error("tx words set without tx_valid");

    // status reports error pending exactly when the count is nonzero
    a_status_err: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> ((out_data_reg[53:51] == STATUS_ERR) == ($past(state_next.tally) != 32'd0)))
        else $error("link status disagrees with error count");

    // error count only falls on a read-clear
    a_tally_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && item_reg.op != OP_READ_CLEAR) |=> (state_reg.tally >= $past(state_reg.tally)))
        else $error("error count fell without read-clear");
`endif

endmodule

`default_nettype wire

>>> tb/link_token_handshake_fsm_checker.sv
`timescale 1ns / 1ps

// Watches both streams and the APB port, predicts every result beat of the
// link state machine and compares it with what the block delivers.
module link_token_handshake_fsm_checker (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    input  wire          s_tready,
    // s_tdata: source_upper, source_lower, dest_upper, dest_lower, reported_flags
    input  wire  [127:0] s_tdata,
    // s_tuser: operation
    input  wire  [2:0]   s_tuser,
    input  wire          m_tvalid,
    input  wire          m_tready,
    // m_tdata: verdict, tx_valid, tx_upper, tx_lower, link_status, errors_seen,
    //          first_error, later_errors, snap_status, snap_known, snap_sent,
    //          peer_address
    input  wire  [271:0] m_tdata,
    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire  [4:0]   paddr,
    input  wire  [31:0]  pwdata,
    input  wire          pready,
    output logic [31:0]  outstanding,
    output logic [31:0]  mismatches
);
    import lths_pkg::*;

    lths_cfg_t    cfg;
    lths_result_t due_reports[$];

    logic [2:0]  phase;
    logic [31:0] sent, known, nxt, hello_cnt;
    logic [47:0] peer;
    logic        peer_ok;
    logic [31:0] tally, first_f, later_f;
    logic [2:0]  snap_ph;
    logic [31:0] snap_kn, snap_sn;

    task automatic log_error(input logic [31:0] flags);
        if (tally == 32'd0) begin
            snap_kn = known;
            snap_sn = sent;
            snap_ph = phase;
            first_f = flags;
        end else begin
            later_f = later_f | flags;
        end
        if (tally != '1) tally = tally + 32'd1;
    endtask

    task automatic drop_link(input logic [2:0] to_phase);
        sent  = 32'd0;
        known = 32'd0;
        nxt   = 32'd0;
        phase = to_phase;
    endtask

    // One link event: updates the tracked state, returns the report it causes
    task automatic step_link(input logic [2:0] op, input logic [127:0] d,
                             output lths_result_t r);
        logic [15:0]       du, kind;
        logic [31:0]       dl, seen;
        logic [47:0]       own, src;
        logic signed [1:0] verdict;
        du      = d[63:48];
        dl      = d[95:64];
        kind    = du & cfg.type_mask;
        own     = {cfg.own_upper, cfg.own_lower};
        src     = {d[15:0], d[47:16]};
        verdict = VERDICT_NONE;
        r       = '0;
        case (op)
            OP_RECEIVE: begin
                // no-op type wins over every phase
                if (kind != cfg.nop_code) begin
                    case (phase)
                        PH_IDLE: ;
                        PH_HELLO: begin
                            if (kind == cfg.hello_code) begin
                                peer    = src;
                                peer_ok = 1'b1;
                                if (own > src) begin
                                    drop_link(PH_WAIT);
                                    verdict = VERDICT_ADV;
                                end else if (own == src) begin
                                    log_error(FLAG_SAME);
                                    phase = PH_IDLE;
                                end
                            end else if (kind == cfg.event_code && dl == 32'd0) begin
                                known   = 32'd0;
                                nxt     = 32'd1;
                                phase   = PH_SEND;
                                verdict = VERDICT_ADV;
                            end
                        end
                        PH_WAIT: begin
                            if (kind == cfg.hello_code) begin
                                if (hello_cnt != '1) hello_cnt = hello_cnt + 32'd1;
                                if (hello_cnt > {16'd0, cfg.hello_limit}) drop_link(PH_HELLO);
                            end else if (kind == cfg.event_code) begin
                                if (dl == sent + 32'd1) begin
                                    known   = dl;
                                    nxt     = dl + 32'd1;
                                    phase   = PH_SEND;
                                    verdict = VERDICT_ADV;
                                end else begin
                                    drop_link(PH_HELLO);
                                end
                            end else begin
                                log_error(FLAG_SEQ);
                                drop_link(PH_HELLO);
                            end
                        end
                        PH_SEND: begin
                            if (!(kind == cfg.event_code && dl == known)) begin
                                log_error(FLAG_SEQ);
                                drop_link(PH_HELLO);
                                verdict = VERDICT_FAIL;
                            end
                        end
                        PH_RECV: begin
                            if (kind == cfg.event_code && known + SEQ_STEP == dl) begin
                                known   = dl;
                                nxt     = dl + 32'd1;
                                phase   = PH_SEND;
                                verdict = VERDICT_ADV;
                            end else if (!(kind == cfg.event_code && known == dl)) begin
                                log_error(FLAG_SEQ);
                                drop_link(PH_HELLO);
                                verdict = VERDICT_FAIL;
                            end
                        end
                        default: begin
                            log_error(FLAG_STATE);
                            drop_link(PH_IDLE);
                        end
                    endcase
                end
            end
            OP_NEXT_TX: begin
                r.tx_valid = 1'b1;
                if (phase == PH_HELLO) begin
                    r.tx_upper = cfg.hello_code;
                    r.tx_lower = cfg.hello_lower;
                end else if (phase == PH_WAIT) begin
                    r.tx_upper = cfg.event_code;
                end else if (phase == PH_SEND) begin
                    r.tx_upper = cfg.event_code;
                    sent       = nxt;
                    nxt        = nxt + SEQ_STEP;
                    r.tx_lower = sent;
                    phase      = PH_RECV;
                end else begin
                    r.tx_upper = cfg.nop_code;
                end
            end
            OP_HELLO_QRY: begin
                if (phase == PH_HELLO) begin
                    r.tx_valid = 1'b1;
                    r.tx_upper = cfg.hello_code;
                    r.tx_lower = cfg.hello_lower;
                end else if (phase == PH_WAIT) begin
                    r.tx_valid = 1'b1;
                    r.tx_upper = cfg.event_code;
                end
            end
            OP_LINK_UP: begin
                if (phase == PH_IDLE) phase = PH_HELLO;
            end
            OP_ERR_REPORT: log_error(d[127:96]);
            default: ;
        endcase
        seen = tally;
        if (op == OP_READ_CLEAR) tally = 32'd0;
        r.verdict      = verdict;
        r.link_status  = (tally != 32'd0) ? STATUS_ERR : phase;
        r.errors_seen  = seen;
        r.first_error  = first_f;
        r.later_errors = later_f;
        r.snap_status  = snap_ph;
        r.snap_known   = snap_kn;
        r.snap_sent    = snap_sn;
        r.peer_address = peer_ok ? peer : 48'd0;
    endtask

    task automatic match_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches = mismatches + 32'd1;
        end
    endtask

    always @(posedge aclk) begin : watch_channels
        lths_result_t want, got;
        if (!aresetn) begin
            cfg.own_upper   = 16'd0;
            cfg.own_lower   = 32'd0;
            cfg.hello_limit = 16'd16;
            cfg.type_mask   = 16'hC000;
            cfg.nop_code    = 16'h0000;
            cfg.hello_code  = 16'h4000;
            cfg.event_code  = 16'h8000;
            cfg.hello_lower = 32'd0;
            drop_link(PH_IDLE);
            hello_cnt  = 32'd0;
            peer       = 48'd0;
            peer_ok    = 1'b0;
            tally      = 32'd0;
            first_f    = 32'd0;
            later_f    = 32'd0;
            snap_ph    = 3'd0;
            snap_kn    = 32'd0;
            snap_sn    = 32'd0;
            mismatches = 32'd0;
            due_reports.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_OWN_UPPER: begin
                        cfg.own_upper = pwdata[15:0];
                        peer_ok       = 1'b0;
                    end
                    REG_OWN_LOWER: begin
                        cfg.own_lower = pwdata;
                        peer_ok       = 1'b0;
                    end
                    REG_HELLO_LIMIT: cfg.hello_limit = pwdata[15:0];
                    REG_TYPE_MASK:   cfg.type_mask   = pwdata[15:0];
                    REG_NOP_CODE:    cfg.nop_code    = pwdata[15:0];
                    REG_HELLO_CODE:  cfg.hello_code  = pwdata[15:0];
                    REG_EVENT_CODE:  cfg.event_code  = pwdata[15:0];
                    REG_HELLO_LOWER: cfg.hello_lower = pwdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                step_link(s_tuser, s_tdata, want);
                due_reports.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                if (due_reports.size() == 0) begin
                    $error("result beat arrived with no report outstanding");
                    mismatches = mismatches + 32'd1;
                end else begin
                    want = due_reports.pop_front();
                    got.verdict      = m_tdata[1:0];
                    got.tx_valid     = m_tdata[2];
                    got.tx_upper     = m_tdata[18:3];
                    got.tx_lower     = m_tdata[50:19];
                    got.link_status  = m_tdata[53:51];
                    got.errors_seen  = m_tdata[85:54];
                    got.first_error  = m_tdata[117:86];
                    got.later_errors = m_tdata[149:118];
                    got.snap_status  = m_tdata[152:150];
                    got.snap_known   = m_tdata[184:153];
                    got.snap_sent    = m_tdata[216:185];
                    got.peer_address = m_tdata[264:217];
                    match_field("verdict", 64'(want.verdict), 64'(got.verdict));
                    match_field("tx_valid", 64'(want.tx_valid), 64'(got.tx_valid));
                    match_field("tx_upper", 64'(want.tx_upper), 64'(got.tx_upper));
                    match_field("tx_lower", 64'(want.tx_lower), 64'(got.tx_lower));
                    match_field("link_status", 64'(want.link_status),
                                64'(got.link_status));
                    match_field("errors_seen", 64'(want.errors_seen),
                                64'(got.errors_seen));
                    match_field("first_error", 64'(want.first_error),
                                64'(got.first_error));
                    match_field("later_errors", 64'(want.later_errors),
                                64'(got.later_errors));
                    match_field("snap_status", 64'(want.snap_status),
                                64'(got.snap_status));
                    match_field("snap_known", 64'(want.snap_known), 64'(got.snap_known));
                    match_field("snap_sent", 64'(want.snap_sent), 64'(got.snap_sent));
                    match_field("peer_address", 64'(want.peer_address),
                                64'(got.peer_address));
                end
            end
        end
        outstanding <= due_reports.size();
    end

endmodule

>>> tb/tb_link_token_handshake_fsm_top.sv
`timescale 1ns / 1ps

module tb_link_token_handshake_fsm_top;
    import lths_pkg::*;

    // Worst case per beat is roughly the longest send gap plus the longest result
    // stall plus the pipeline; the limit is several times that over ~650 beats.
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_BEATS  = 600;
    localparam int SETTING_COUNT = 7;

    // Field layout of s_tdata, first declared member ends up in the top bits
    typedef struct packed {
        logic [31:0] flags;
        logic [31:0] dest_lower;
        logic [15:0] dest_upper;
        logic [31:0] source_lower;
        logic [15:0] source_upper;
    } beat_fields_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic [127:0] s_tdata  = '0;
    logic [2:0]   s_tuser  = '0;
    logic         m_tready = 1'b0;
    logic         psel     = 1'b0;
    logic         penable  = 1'b0;
    logic         pwrite   = 1'b0;
    logic [4:0]   paddr    = '0;
    logic [31:0]  pwdata   = '0;
    wire          s_tready;
    wire          m_tvalid;
    wire  [271:0] m_tdata;
    wire  [31:0]  prdata;
    wire          pready;
    wire  [31:0]  outstanding;
    wire  [31:0]  mismatches;

    int unsigned  cycle_count = 0;
    int unsigned  beats_done  = 0;
    bit           quiet_stretch = 1'b0;

    // What has been written to the block, so stimulus can be made to fit it
    logic [47:0]  set_own         = 48'd0;
    logic [15:0]  set_mask        = 16'hC000;
    logic [15:0]  set_nop         = 16'h0000;
    logic [15:0]  set_hello       = 16'h4000;
    logic [15:0]  set_event       = 16'h8000;

    link_token_handshake_fsm_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    link_token_handshake_fsm_checker link_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog: a hung handshake or a lost result ends up here
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // Idle length for either side: mostly none or short, now and then long,
    // nothing at all while a quiet stretch is running.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_stretch || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side back-pressure, independent of the sender
    initial begin : result_sink
        int stall;
        forever begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge aclk);
            stall = pick_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    // Holds the beat until the block takes it; tvalid stays high when the
    // next beat follows without a gap.
    task automatic push_beat(input logic [2:0] op, input beat_fields_t f);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= f;
        do @(posedge aclk); while (!s_tready);
        if (op <= OP_READ_CLEAR) beats_done++;
    endtask

    function automatic beat_fields_t random_fields();
        beat_fields_t f;
        f.source_upper = 16'($urandom);
        f.source_lower = $urandom;
        f.dest_upper   = 16'($urandom);
        f.dest_lower   = $urandom;
        f.flags        = $urandom;
        return f;
    endfunction

    // Message type code, with random junk in the bits the mask drops
    function automatic logic [15:0] type_word(input logic [15:0] code);
        logic [15:0] junk;
        junk = 16'($urandom);
        return code | (junk & ~set_mask);
    endfunction

    task automatic send_message(input logic [15:0] code, input logic [31:0] seq);
        beat_fields_t f;
        f = random_fields();
        f.dest_upper = type_word(code);
        f.dest_lower = seq;
        push_beat(OP_RECEIVE, f);
    endtask

    task automatic send_hello(input logic [47:0] from);
        beat_fields_t f;
        f = random_fields();
        f.dest_upper   = type_word(set_hello);
        f.source_upper = from[47:32];
        f.source_lower = from[31:0];
        push_beat(OP_RECEIVE, f);
    endtask

    // Let every outstanding result come back; the block is idle afterwards
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_settings(input logic [47:0] own, input logic [15:0] limit,
                                 input logic [15:0] mask, input logic [15:0] nop,
                                 input logic [15:0] hello, input logic [15:0] evt,
                                 input logic [31:0] hello_lower);
        apb_write(REG_OWN_UPPER, {16'd0, own[47:32]});
        apb_write(REG_OWN_LOWER, own[31:0]);
        apb_write(REG_HELLO_LIMIT, {16'd0, limit});
        apb_write(REG_TYPE_MASK, {16'd0, mask});
        apb_write(REG_NOP_CODE, {16'd0, nop});
        apb_write(REG_HELLO_CODE, {16'd0, hello});
        apb_write(REG_EVENT_CODE, {16'd0, evt});
        apb_write(REG_HELLO_LOWER, hello_lower);
        set_own   = own;
        set_mask  = mask;
        set_nop   = nop;
        set_hello = hello;
        set_event = evt;
    endtask

    // Link up, then a far-off event: given distinct type codes this leaves the link
    // in hello in any phase (idle goes up, a stray event drops wait/send/receive).
    task automatic resync();
        logic [31:0] stray;
        stray = {1'b1, 30'($urandom), 1'b1};
        push_beat(OP_LINK_UP, random_fields());
        send_message(set_event, stray);
    endtask

    // Out-of-order noise: any operation, random fields, sometimes a typed
    // message with a small sequence number.
    task automatic noise_beat();
        beat_fields_t f;
        logic [2:0]   op;
        f  = random_fields();
        op = 3'($urandom_range(0, 7));
        if (op == OP_RECEIVE && $urandom_range(0, 1)) begin
            case ($urandom_range(0, 2))
                0: f.dest_upper = type_word(set_nop);
                1: f.dest_upper = type_word(set_hello);
                default: f.dest_upper = type_word(set_event);
            endcase
            f.dest_lower = $urandom_range(0, 8);
        end
        push_beat(op, f);
    endtask

    // A well-formed link session: hello arbitration, then alternating
    // transmit / receive with the sequence moving in steps of two, with the
    // odd duplicate, query or error mixed in, and a random ending.
    task automatic run_session();
        logic [47:0] span, pick, peer_addr, top_addr;
        logic [31:0] seq;
        bit          win;
        beat_fields_t f;
        top_addr = '1;
        resync();
        if ($urandom_range(0, 11) == 0) begin
            // peer claims our own address
            send_hello(set_own);
            return;
        end
        if (set_own == 48'd0) win = 1'b0;
        else if (set_own == top_addr) win = 1'b1;
        else win = 1'($urandom_range(0, 1));
        span = win ? set_own : (top_addr - set_own);
        pick = 48'({$urandom, $urandom} % {16'd0, span});
        if ($urandom_range(0, 7) == 0) pick = span - 48'd1;
        peer_addr = win ? pick : set_own + 48'd1 + pick;
        if ($urandom_range(0, 3) == 0) push_beat(OP_HELLO_QRY, random_fields());
        send_hello(peer_addr);
        if (win) begin
            // we hold the larger address: wait for the peer's first event
            if ($urandom_range(0, 1)) push_beat(OP_NEXT_TX, random_fields());
            if ($urandom_range(0, 3) == 0) push_beat(OP_HELLO_QRY, random_fields());
            seq = 32'd1;
        end else begin
            seq = 32'd0;
        end
        send_message(set_event, seq);
        repeat ($urandom_range(1, 12)) begin
            push_beat(OP_NEXT_TX, random_fields());
            if ($urandom_range(0, 5) == 0) begin
                f = random_fields();
                case ($urandom_range(0, 4))
                    0: send_message(set_event, seq);
                    1: push_beat(OP_HELLO_QRY, f);
                    2: push_beat(OP_ERR_REPORT, f);
                    3: push_beat(OP_READ_CLEAR, f);
                    default: send_message(set_nop, f.dest_lower);
                endcase
            end
            seq = seq + SEQ_STEP;
            send_message(set_event, seq);
        end
        case ($urandom_range(0, 5))
            0: send_message(set_event, seq + 32'd3);
            1: send_hello(peer_addr);
            2: begin
                push_beat(OP_NEXT_TX, random_fields());
                send_message(set_event, seq + 32'd6);
            end
            3: push_beat(OP_ERR_REPORT, random_fields());
            4: push_beat(OP_READ_CLEAR, random_fields());
            default: ;
        endcase
    endtask

    // Straight after reset, on the default register values (own address 0)
    task automatic directed_beats();
        beat_fields_t ones;
        beat_fields_t f;
        ones = '1;
        send_message(set_event, 32'd0);              // receive while idle
        push_beat(OP_NEXT_TX, random_fields());      // idle transmit gives no-op
        push_beat(OP_HELLO_QRY, random_fields());
        push_beat(3'd6, random_fields());            // undefined operations
        push_beat(3'd7, ones);
        push_beat(OP_LINK_UP, random_fields());
        push_beat(OP_HELLO_QRY, random_fields());
        push_beat(OP_NEXT_TX, random_fields());
        send_hello(48'd0);                           // same address as ours
        f = random_fields();
        f.flags = '1;
        push_beat(OP_ERR_REPORT, f);                 // later error, ORed in
        push_beat(OP_READ_CLEAR, random_fields());
        push_beat(OP_LINK_UP, random_fields());
        f = ones;
        f.dest_upper = 16'h3FFF;                     // masked type is the no-op
        push_beat(OP_RECEIVE, f);
        send_hello('1);                              // peer larger, we stay in hello
        send_message(set_event, 32'd0);              // first event: to send
        send_message(set_event, 32'd0);              // repeat in send, no action
        push_beat(OP_NEXT_TX, random_fields());
        send_message(set_event, 32'd0);              // repeat in receive, no action
        send_message(set_event, 32'd2);
        push_beat(OP_NEXT_TX, random_fields());
        send_message(set_event, 32'd9);              // out of sequence in receive
        send_message(set_event, 32'd0);
        send_hello('1);                              // wrong type in send
        f = random_fields();
        f.flags = 32'd0;
        push_beat(OP_ERR_REPORT, f);
        push_beat(OP_READ_CLEAR, random_fields());
    endtask

    initial begin : stimulus
        int unsigned target;
        logic [47:0] own;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed_beats();

        for (int n = 0; n < SETTING_COUNT; n++) begin
            // registers only change with the block idle
            drain();
            repeat (4) @(posedge aclk);
            own = 48'({$urandom, $urandom});
            case (n)
                0: load_settings(own, 16'd16, 16'hC000, 16'h0000, 16'h4000, 16'h8000,
                                 $urandom);
                1: load_settings(own, 16'd0, 16'hF000, 16'h3000, 16'hA000, 16'h5000,
                                 $urandom);
                2: load_settings('1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFE, 16'h0001,
                                 32'hFFFF_FFFF);
                3: load_settings(48'd0, 16'($urandom), 16'h0000, 16'h0000, 16'h0000,
                                 16'h0000, 32'd0);
                // hello and event share one code: hello takes precedence
                4: load_settings(own, 16'd2, 16'hC000, 16'h0000, 16'h4000, 16'h4000,
                                 $urandom);
                5: load_settings(own, 16'($urandom), 16'($urandom), 16'($urandom),
                                 16'($urandom), 16'($urandom), $urandom);
                default: load_settings(own, 16'd16, 16'hC000, 16'h0000, 16'h4000,
                                       16'h8000, 32'd0);
            endcase
            target = beats_done + RANDOM_BEATS / SETTING_COUNT;
            while (beats_done < target) begin
                if ($urandom_range(0, 4) == 0) quiet_stretch = !quiet_stretch;
                if ($urandom_range(0, 3) != 0) run_session();
                else repeat ($urandom_range(1, 6)) noise_beat();
            end
        end

        drain();
        // the extra wait catches any stray result beat
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/lths_pkg.sv
rtl/core/lths_step.sv
rtl/core/link_token_handshake_fsm_top.sv
tb/link_token_handshake_fsm_checker.sv
tb/tb_link_token_handshake_fsm_top.sv
